// ===== hdl/multicart_address_latch_banker_defines.svh =====
// ----------------------------------------------------------------------------
// Multicart address latch banker: assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTICART_ADDRESS_LATCH_BANKER_DEFINES_SVH
`define MULTICART_ADDRESS_LATCH_BANKER_DEFINES_SVH

// Same-cycle implication
`define MCALB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MCALB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mcalb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcalb_pkg
// Types, codes and constants shared by the multicart address latch banker.
// ----------------------------------------------------------------------------
`default_nettype none

package mcalb_pkg;

    // Default number of scratch cells
    localparam int ScratchCellsDef = 4;

    // Configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 11;
    localparam logic [CfgIdxW-1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIRROR    = 2'd2;

    // Access modes
    localparam logic [1:0] MODE_CPU_WR = 2'd0;
    localparam logic [1:0] MODE_CPU_RD = 2'd1;
    localparam logic [1:0] MODE_PPU    = 2'd2;

    // Mirroring codes
    localparam logic [1:0] MIR_VERT = 2'd0;
    localparam logic [1:0] MIR_HORZ = 2'd1;
    localparam logic [1:0] MIR_FOUR = 2'd2;

    // Address windows
    localparam logic [15:0] ExpLo     = 16'h4020;
    localparam logic [15:0] ScratchLo = 16'h5800;
    localparam logic [15:0] ScratchHi = 16'h5FFF;

    // Remainder unit sizing
    localparam int DvdW  = 16;
    localparam int DvsW  = 11;
    localparam int StepW = 4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_driven;
        logic [7:0] prg_bank;
        logic [9:0] chr_bank;
        logic       chr_is_ram;
        logic [1:0] mirroring;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mcalb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcalb_ctrl
// Sequencer: accepts a request, runs the remainder unit, commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multicart_address_latch_banker_defines.svh"

module mcalb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mcalb_pkg::dp_cmd_t      cmd,
    input  wire mcalb_pkg::dp_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       commit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    // commit only into an empty or draining output register
    assign commit    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign cmd.load   = accept;
    assign cmd.step   = (state_reg == S_RUN);
    assign cmd.commit = commit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MCALB_ASSERT_NXT(a_accept_runs, accept, state_reg == S_RUN, "accept did not start run")
    `MCALB_ASSERT_NXT(a_done_fin, stat.div_done, state_reg == S_FIN, "remainder done lost")
    `MCALB_ASSERT_NXT(a_commit_valid, commit, out_valid_reg, "committed result not shown")
    `MCALB_ASSERT_NXT(a_fin_holds, (state_reg == S_FIN) && out_valid_reg && !out_ready,
        state_reg == S_FIN, "result committed over a waiting one")

endmodule

`default_nettype wire

// ===== hdl/mcalb_dp.sv =====
// ----------------------------------------------------------------------------
// mcalb_dp
// Datapath: config registers, bank latch, scratch cells, serial remainder
// unit and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcalb_dp #(
    parameter int SCRATCH_CELLS = mcalb_pkg::ScratchCellsDef
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mcalb_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [mcalb_pkg::CfgDataW-1:0]   cfg_data,
    input  wire mcalb_pkg::in_item_t              in_item,
    input  wire mcalb_pkg::dp_cmd_t               cmd,
    output mcalb_pkg::dp_stat_t                   stat,
    output mcalb_pkg::out_item_t                  out_item
);

    localparam int IdxW = (SCRATCH_CELLS > 1) ? $clog2(SCRATCH_CELLS) : 1;
    localparam int DvdW = mcalb_pkg::DvdW;
    localparam int DvsW = mcalb_pkg::DvsW;

    // configuration
    logic [8:0]  prg_cnt_reg;
    logic [10:0] chr_cnt_reg;
    logic [1:0]  hdr_mir_reg;

    // board state
    logic [14:0] latch_reg, latch_next;
    logic        written_reg, written_next;
    logic [3:0]  cell_reg [SCRATCH_CELLS];

    // current request
    mcalb_pkg::in_item_t item_reg;

    // remainder unit
    logic [DvdW-1:0]                 dvd_reg;
    logic [DvsW-1:0]                 dvs_reg;
    logic [DvsW-1:0]                 rem_reg, rem_next;
    logic [mcalb_pkg::StepW-1:0]     cnt_reg;
    logic [DvsW:0]                   trial;

    mcalb_pkg::out_item_t out_reg, out_next;

    logic [14:0]     eff_latch;
    logic [6:0]      page_prg;
    logic [6:0]      page_chr;
    logic [7:0]      prg_raw;
    logic [9:0]      chr_raw;
    logic [DvdW-1:0] dvd_load;
    logic [DvsW-1:0] dvs_load;
    logic [IdxW-1:0] cell_idx;
    logic            in_scratch;
    logic            in_exp;
    logic            cell_we;
    logic [14:0]     eff_post;

    // effective latch before the first latch write follows the header
    always_comb
    begin
        if (written_reg)
        begin
            eff_latch = latch_reg;
        end
        else if (hdr_mir_reg == mcalb_pkg::MIR_HORZ)
        begin
            eff_latch = 15'h2000;
        end
        else
        begin
            eff_latch = 15'h0000;
        end
    end

    // raw page numbers from the incoming request
    assign page_prg = {eff_latch[14], eff_latch[11:6]};
    assign page_chr = {eff_latch[14], eff_latch[5:0]};
    assign prg_raw  = eff_latch[12] ? {page_prg, in_item.address[13]}
                                    : {page_prg[6:1], in_item.address[14:13]};
    assign chr_raw  = {page_chr, in_item.address[12:10]};

    // choose the remainder operands
    always_comb
    begin
        if ((in_item.mode == mcalb_pkg::MODE_CPU_RD) && in_item.address[15])
        begin
            dvd_load = DvdW'(prg_raw);
            dvs_load = (prg_cnt_reg == 9'd0) ? DvsW'(1) : DvsW'(prg_cnt_reg);
        end
        else if ((in_item.mode == mcalb_pkg::MODE_PPU) && (chr_cnt_reg != 11'd0))
        begin
            dvd_load = DvdW'(chr_raw);
            dvs_load = chr_cnt_reg;
        end
        else
        begin
            // scratch cell select: address modulo cell count
            dvd_load = in_item.address;
            dvs_load = DvsW'(SCRATCH_CELLS);
        end
    end

    // one restoring step: shift in a dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[DvdW-1]};
    always_comb
    begin
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DvsW'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[DvsW-1:0];
        end
    end

    assign stat.div_done = cmd.step && (cnt_reg == {mcalb_pkg::StepW{1'b1}});

    // result decode at commit
    assign cell_idx   = rem_reg[IdxW-1:0];
    assign in_scratch = (item_reg.address >= mcalb_pkg::ScratchLo)
                     && (item_reg.address <= mcalb_pkg::ScratchHi);
    assign in_exp     = (item_reg.address >= mcalb_pkg::ExpLo)
                     && (item_reg.address <= mcalb_pkg::ScratchHi);
    assign cell_we    = cmd.commit && (item_reg.mode == mcalb_pkg::MODE_CPU_WR)
                     && in_scratch;

    // latch update
    always_comb
    begin
        latch_next   = latch_reg;
        written_next = written_reg;
        if ((item_reg.mode == mcalb_pkg::MODE_CPU_WR) && item_reg.address[15])
        begin
            latch_next   = item_reg.address[14:0];
            written_next = 1'b1;
        end
    end

    // mirroring seen after this request
    always_comb
    begin
        if (written_next)
        begin
            eff_post = latch_next;
        end
        else
        begin
            eff_post = eff_latch;
        end
    end

    // output fields
    always_comb
    begin
        out_next = '0;
        case (item_reg.mode)
            mcalb_pkg::MODE_CPU_RD:
            begin
                if (item_reg.address[15])
                begin
                    out_next.prg_bank = rem_reg[7:0];
                end
                else if (in_exp)
                begin
                    out_next.read_driven = 1'b1;
                    if (in_scratch)
                    begin
                        out_next.read_data = {4'h0, cell_reg[cell_idx]};
                    end
                    else
                    begin
                        out_next.read_data = item_reg.address[15:8];
                    end
                end
            end
            mcalb_pkg::MODE_PPU:
            begin
                if (chr_cnt_reg == 11'd0)
                begin
                    out_next.chr_is_ram = 1'b1;
                    out_next.chr_bank   = {7'd0, item_reg.address[12:10]};
                end
                else
                begin
                    out_next.chr_bank = rem_reg[9:0];
                end
            end
            default:
            begin
                out_next.read_data = 8'h00;
            end
        endcase
        if (hdr_mir_reg[1])
        begin
            out_next.mirroring = mcalb_pkg::MIR_FOUR;
        end
        else if (eff_post[13])
        begin
            out_next.mirroring = mcalb_pkg::MIR_HORZ;
        end
        else
        begin
            out_next.mirroring = mcalb_pkg::MIR_VERT;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_cnt_reg <= 9'd1;
            chr_cnt_reg <= 11'd0;
            hdr_mir_reg <= mcalb_pkg::MIR_VERT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcalb_pkg::CFG_PRG_COUNT: prg_cnt_reg <= cfg_data[8:0];
                mcalb_pkg::CFG_CHR_COUNT: chr_cnt_reg <= cfg_data;
                mcalb_pkg::CFG_MIRROR:    hdr_mir_reg <= cfg_data[1:0];
                default:                  prg_cnt_reg <= prg_cnt_reg;
            endcase
        end
    end

    // bank latch and scratch cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            written_reg <= 1'b0;
            for (int i = 0; i < SCRATCH_CELLS; i++)
            begin
                cell_reg[i] <= 4'h0;
            end
        end
        else if (cmd.commit)
        begin
            latch_reg   <= latch_next;
            written_reg <= written_next;
            if (cell_we)
            begin
                cell_reg[cell_idx] <= item_reg.write_data[3:0];
            end
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // request capture, remainder unit and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            dvd_reg  <= dvd_load;
            dvs_reg  <= dvs_load;
            rem_reg  <= '0;
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[DvdW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// ===== hdl/multicart_address_latch_banker.sv =====
// ----------------------------------------------------------------------------
// multicart_address_latch_banker
// Multicart bank board: address latch, PRG/CHR banking, scratch cells.
// ----------------------------------------------------------------------------
// Each request is one bus access and yields one result. A request is taken
// when the block is idle, then a 16-step restoring remainder unit reduces
// the bank number by the page count (or the address by the scratch cell
// count), and the finish state then commits board state and loads the output
// register, waiting while an unaccepted result still sits there. The next
// request is taken only after the current one has committed. A finished
// result may wait in the output register while the next request is taken.
// Configuration writes take effect at once and belong to idle periods.
`default_nettype none

module multicart_address_latch_banker #(
    parameter int SCRATCH_CELLS = mcalb_pkg::ScratchCellsDef
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire mcalb_pkg::in_item_t            in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output mcalb_pkg::out_item_t                out_item,
    input  wire logic                           cfg_we,
    input  wire logic [mcalb_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [mcalb_pkg::CfgDataW-1:0] cfg_data
);

    mcalb_pkg::dp_cmd_t  cmd;
    mcalb_pkg::dp_stat_t stat;

    // sequencer
    mcalb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath
    mcalb_dp #(
        .SCRATCH_CELLS (SCRATCH_CELLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
